### rtl/rbe_pkg.sv
`timescale 1ns / 1ps
// rbe_pkg: shared types, request codes and micro-step numbers for the
// resonator bank energy block; used by every rtl file, depends on nothing
package rbe_pkg;

    localparam int NUM_BANDS  = 128;
    localparam int BAND_W     = 7;
    localparam int CNT_W      = 8;
    localparam int ACC_W      = 98;
    localparam int PROD_W     = 60;
    localparam int OP_W       = 5;

    // request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // configuration register indexes
    localparam logic CFG_ACTIVE_BANDS = 1'b0;
    localparam logic CFG_STEREO       = 1'b1;

    // micro-steps of one band update
    localparam logic [OP_W-1:0] OP_RE_XL_C  = 5'd0;
    localparam logic [OP_W-1:0] OP_RE_XH_C  = 5'd1;
    localparam logic [OP_W-1:0] OP_RE_YL_S  = 5'd2;
    localparam logic [OP_W-1:0] OP_RE_YH_S  = 5'd3;
    localparam logic [OP_W-1:0] OP_IM_YL_C  = 5'd4;
    localparam logic [OP_W-1:0] OP_IM_YH_C  = 5'd5;
    localparam logic [OP_W-1:0] OP_IM_XL_S  = 5'd6;
    localparam logic [OP_W-1:0] OP_IM_XH_S  = 5'd7;
    localparam logic [OP_W-1:0] OP_DX_L     = 5'd8;
    localparam logic [OP_W-1:0] OP_DX_H     = 5'd9;
    localparam logic [OP_W-1:0] OP_DY_L     = 5'd10;
    localparam logic [OP_W-1:0] OP_DY_H     = 5'd11;
    localparam logic [OP_W-1:0] OP_SQX_LL   = 5'd12;
    localparam logic [OP_W-1:0] OP_SQX_HL   = 5'd13;
    localparam logic [OP_W-1:0] OP_SQX_HH   = 5'd14;
    localparam logic [OP_W-1:0] OP_SQY_LL   = 5'd15;
    localparam logic [OP_W-1:0] OP_SQY_HL   = 5'd16;
    localparam logic [OP_W-1:0] OP_SQY_HH   = 5'd17;
    localparam logic [OP_W-1:0] OP_SC_L     = 5'd18;
    localparam logic [OP_W-1:0] OP_SC_M     = 5'd19;
    localparam logic [OP_W-1:0] OP_SC_H     = 5'd20;
    localparam logic [OP_W-1:0] OP_LAST     = OP_SC_H;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [6:0]         band;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [31:0] coef_cos;
        logic signed [31:0] coef_sin;
        logic [31:0]        coef_decay;
        logic [31:0]        coef_scale;
    } t_in_beat;

    typedef struct packed {
        logic [6:0]  out_band;
        logic [63:0] energy;
        logic        saturated;
    } t_out_beat;

    // one coefficient entry
    typedef struct packed {
        logic [31:0]        scale;
        logic [31:0]        decay;
        logic signed [31:0] sin;
        logic signed [31:0] cos;
    } t_coef;

    // one state entry
    typedef struct packed {
        logic               sat;
        logic [63:0]        energy;
        logic signed [47:0] im;
        logic signed [47:0] re;
    } t_state;

    // control from sequencer to datapath
    typedef struct packed {
        logic            latch;
        logic            mul;
        logic            acc;
        logic [OP_W-1:0] op;
    } t_dp_ctrl;

endpackage

### rtl/rbe_coef_mem.sv
`timescale 1ns / 1ps
// rbe_coef_mem: per-band coefficient memory, one write and one registered read
// depends on rbe_pkg
module rbe_coef_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [rbe_pkg::BAND_W-1:0] i_waddr,
    input  rbe_pkg::t_coef             i_wdata,
    input  logic                       i_re,
    input  logic [rbe_pkg::BAND_W-1:0] i_raddr,
    output rbe_pkg::t_coef             o_rdata
);

    rbe_pkg::t_coef r_mem [rbe_pkg::NUM_BANDS];
    rbe_pkg::t_coef r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

### rtl/rbe_state_mem.sv
`timescale 1ns / 1ps
// rbe_state_mem: per-band oscillator and energy memory with valid bits so that
// an entry never written reads as zero; depends on rbe_pkg
module rbe_state_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [rbe_pkg::BAND_W-1:0] i_waddr,
    input  rbe_pkg::t_state            i_wdata,
    input  logic                       i_re,
    input  logic [rbe_pkg::BAND_W-1:0] i_raddr,
    output rbe_pkg::t_state            o_rdata
);

    rbe_pkg::t_state             r_mem [rbe_pkg::NUM_BANDS];
    rbe_pkg::t_state             r_q;
    logic [rbe_pkg::NUM_BANDS-1:0] r_vld;
    logic                        r_vld_q;

    // data array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_vld_q <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_vld_q ? r_q : '0;

endmodule

### rtl/rbe_datapath.sv
`timescale 1ns / 1ps
// rbe_datapath: shared 27x33 multiplier and wide accumulator that step one band
// through rotation, decay, squared magnitude and energy; depends on rbe_pkg
module rbe_datapath (
    input  logic               i_clk,
    input  rbe_pkg::t_dp_ctrl  i_ctrl,
    input  rbe_pkg::t_coef     i_coef,
    input  rbe_pkg::t_state    i_state,
    input  logic signed [16:0] i_smp,
    output rbe_pkg::t_state    o_state
);

    localparam logic signed [55:0] MAX48 = 56'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [55:0] MIN48 = -MAX48 - 56'sd1;

    logic signed [47:0] r_x, r_y;
    logic signed [31:0] r_c, r_s;
    logic [31:0]        r_d, r_sc;
    logic [63:0]        r_e;
    logic               r_sat;
    logic signed [51:0] r_rx, r_ry;
    logic signed [47:0] r_nx, r_ny;
    logic [63:0]        r_m;
    logic [63:0]        r_term;
    logic signed [rbe_pkg::PROD_W-1:0] r_prod;
    logic signed [rbe_pkg::ACC_W-1:0]  r_acc;

    logic signed [26:0] mul_a;
    logic signed [32:0] mul_b;
    logic [6:0]         shamt;
    logic               neg, clr;
    logic signed [rbe_pkg::ACC_W-1:0] prod_ext, prod_sh, n_acc;
    logic signed [55:0] n_xsum, n_ysum;
    logic [64:0]        e_sum;
    logic [63:0]        e_new;

    // operand select per micro-step, upper halves keep their sign
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_ctrl.op)
            rbe_pkg::OP_RE_XL_C: begin mul_a = {1'b0, r_x[25:0]};  mul_b = 33'(r_c); end
            rbe_pkg::OP_RE_XH_C: begin mul_a = 27'($signed(r_x[47:26])); mul_b = 33'(r_c); end
            rbe_pkg::OP_RE_YL_S: begin mul_a = {1'b0, r_y[25:0]};  mul_b = 33'(r_s); end
            rbe_pkg::OP_RE_YH_S: begin mul_a = 27'($signed(r_y[47:26])); mul_b = 33'(r_s); end
            rbe_pkg::OP_IM_YL_C: begin mul_a = {1'b0, r_y[25:0]};  mul_b = 33'(r_c); end
            rbe_pkg::OP_IM_YH_C: begin mul_a = 27'($signed(r_y[47:26])); mul_b = 33'(r_c); end
            rbe_pkg::OP_IM_XL_S: begin mul_a = {1'b0, r_x[25:0]};  mul_b = 33'(r_s); end
            rbe_pkg::OP_IM_XH_S: begin mul_a = 27'($signed(r_x[47:26])); mul_b = 33'(r_s); end
            rbe_pkg::OP_DX_L: begin mul_a = {1'b0, r_rx[25:0]}; mul_b = {1'b0, r_d}; end
            rbe_pkg::OP_DX_H: begin
                mul_a = 27'($signed(r_rx[51:26]));
                mul_b = {1'b0, r_d};
            end
            rbe_pkg::OP_DY_L: begin mul_a = {1'b0, r_ry[25:0]}; mul_b = {1'b0, r_d}; end
            rbe_pkg::OP_DY_H: begin
                mul_a = 27'($signed(r_ry[51:26]));
                mul_b = {1'b0, r_d};
            end
            rbe_pkg::OP_SQX_LL: begin mul_a = {1'b0, r_nx[25:0]}; mul_b = {7'b0, r_nx[25:0]}; end
            rbe_pkg::OP_SQX_HL: begin
                mul_a = 27'($signed(r_nx[47:26]));
                mul_b = {7'b0, r_nx[25:0]};
            end
            rbe_pkg::OP_SQX_HH: begin
                mul_a = 27'($signed(r_nx[47:26]));
                mul_b = 33'($signed(r_nx[47:26]));
            end
            rbe_pkg::OP_SQY_LL: begin mul_a = {1'b0, r_ny[25:0]}; mul_b = {7'b0, r_ny[25:0]}; end
            rbe_pkg::OP_SQY_HL: begin
                mul_a = 27'($signed(r_ny[47:26]));
                mul_b = {7'b0, r_ny[25:0]};
            end
            rbe_pkg::OP_SQY_HH: begin
                mul_a = 27'($signed(r_ny[47:26]));
                mul_b = 33'($signed(r_ny[47:26]));
            end
            rbe_pkg::OP_SC_L:    begin mul_a = {1'b0, r_m[25:0]};     mul_b = {1'b0, r_sc}; end
            rbe_pkg::OP_SC_M:    begin mul_a = {1'b0, r_m[51:26]};    mul_b = {1'b0, r_sc}; end
            rbe_pkg::OP_SC_H:    begin mul_a = {15'b0, r_m[63:52]};   mul_b = {1'b0, r_sc}; end
            default:             begin mul_a = '0;                    mul_b = '0; end
        endcase
    end

    // weight, sign and start flag of each partial product
    always_comb begin
        shamt = 7'd0;
        neg   = 1'b0;
        clr   = 1'b0;
        unique case (i_ctrl.op)
            rbe_pkg::OP_RE_XL_C, rbe_pkg::OP_IM_YL_C, rbe_pkg::OP_DX_L,
            rbe_pkg::OP_DY_L, rbe_pkg::OP_SQX_LL, rbe_pkg::OP_SC_L: clr = 1'b1;
            rbe_pkg::OP_RE_YL_S:                                     neg = 1'b1;
            rbe_pkg::OP_RE_YH_S: begin neg = 1'b1; shamt = 7'd26; end
            rbe_pkg::OP_RE_XH_C, rbe_pkg::OP_IM_YH_C, rbe_pkg::OP_IM_XH_S,
            rbe_pkg::OP_DX_H, rbe_pkg::OP_DY_H, rbe_pkg::OP_SC_M:   shamt = 7'd26;
            rbe_pkg::OP_SQX_HL, rbe_pkg::OP_SQY_HL:                  shamt = 7'd27;
            rbe_pkg::OP_SQX_HH, rbe_pkg::OP_SQY_HH, rbe_pkg::OP_SC_H: shamt = 7'd52;
            default: begin shamt = 7'd0; neg = 1'b0; clr = 1'b0; end
        endcase
    end

    // accumulate the registered product
    always_comb begin
        prod_ext = {{(rbe_pkg::ACC_W - rbe_pkg::PROD_W){r_prod[rbe_pkg::PROD_W-1]}}, r_prod};
        prod_sh  = prod_ext <<< shamt;
        if (clr) begin
            n_acc = neg ? -prod_sh : prod_sh;
        end else begin
            n_acc = neg ? r_acc - prod_sh : r_acc + prod_sh;
        end
        n_xsum = $signed(n_acc[87:32]) + {{23{i_smp[16]}}, i_smp, 16'b0};
        n_ysum = $signed(n_acc[87:32]);
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_x   <= i_state.re;
            r_y   <= i_state.im;
            r_e   <= i_state.energy;
            r_sat <= i_state.sat;
            r_c   <= i_coef.cos;
            r_s   <= i_coef.sin;
            r_d   <= i_coef.decay;
            r_sc  <= i_coef.scale;
        end
        if (i_ctrl.mul) begin
            r_prod <= rbe_pkg::PROD_W'(mul_a) * rbe_pkg::PROD_W'(mul_b);
        end
        if (i_ctrl.acc) begin
            r_acc <= n_acc;
            unique case (i_ctrl.op)
                rbe_pkg::OP_RE_YH_S: r_rx <= n_acc[81:30];
                rbe_pkg::OP_IM_XH_S: r_ry <= n_acc[81:30];
                rbe_pkg::OP_DX_H: begin
                    if (n_xsum > MAX48)      r_nx <= MAX48[47:0];
                    else if (n_xsum < MIN48) r_nx <= MIN48[47:0];
                    else                     r_nx <= n_xsum[47:0];
                end
                rbe_pkg::OP_DY_H: begin
                    if (n_ysum > MAX48)      r_ny <= MAX48[47:0];
                    else if (n_ysum < MIN48) r_ny <= MIN48[47:0];
                    else                     r_ny <= n_ysum[47:0];
                end
                rbe_pkg::OP_SQY_HH: r_m <= n_acc[95:32];
                rbe_pkg::OP_SC_H:   r_term <= (|n_acc[97:80]) ? '1 : n_acc[79:16];
                default: ;
            endcase
        end
    end

    // saturating energy update
    always_comb begin
        e_sum = {1'b0, r_e} + {1'b0, r_term};
        e_new = e_sum[64] ? '1 : e_sum[63:0];
        o_state.re     = r_nx;
        o_state.im     = r_ny;
        o_state.energy = e_new;
        o_state.sat    = r_sat | (&e_new);
    end

endmodule

### rtl/resonator_bank_energy_core.sv
`timescale 1ns / 1ps
// resonator_bank_energy_core: top level, request sequencer and memories
// depends on rbe_pkg, rbe_coef_mem, rbe_state_mem, rbe_datapath
//
// Usage
//  input channel  : i_in_valid / o_in_stall / i_in_data, one request per beat
//  output channel : o_out_valid / i_out_stall / o_out_data, one beat per read
//  config port    : i_cfg_we, i_cfg_idx, i_cfg_data; write only while idle
// Sequence
//  a load writes the coefficients at acceptance, then the
//  band's state entry is read and written back with the oscillator cleared
//  a read reads the band's state entry, then fills the output register once
//  it is free; the beat sits there until taken while the next request is accepted
//  a sample walks the active bands in order, per band one memory read, one
//  latch, 21 multiply/accumulate steps on the shared 27x33 multiplier, each
//  a multiply state then an accumulate state, and one write-back
//  o_in_stall is high after acceptance until the request is done
// Reset
//  configuration returns to 94 bands and mono, all oscillator and energy
//  entries read as zero; a read stalls in place while the receiver stalls
module resonator_bank_energy_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rbe_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rbe_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_LAT  = 6'b000100,
        S_MUL  = 6'b001000,
        S_ACC  = 6'b010000,
        S_WB   = 6'b100000
    } t_fsm;

    t_fsm r_state, n_state;

    logic [rbe_pkg::CNT_W-1:0]  r_active;
    logic                       r_stereo;
    logic [1:0]                 r_req;
    logic [rbe_pkg::BAND_W-1:0] r_addr;
    logic signed [16:0]         r_smp;
    logic [rbe_pkg::OP_W-1:0]   r_op;
    logic                       r_out_valid;
    rbe_pkg::t_out_beat         r_out;

    logic                       in_acc;
    logic [rbe_pkg::CNT_W-1:0]  n_bands;
    logic                       last_band;
    logic                       out_free;
    logic signed [16:0]         smp_in;

    logic                       coef_we;
    rbe_pkg::t_coef             coef_wdata, coef_rdata;
    logic                       st_we, st_re;
    rbe_pkg::t_state            st_wdata, st_rdata, dp_state;
    rbe_pkg::t_dp_ctrl          dp_ctrl;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign n_bands   = (r_active > rbe_pkg::CNT_W'(rbe_pkg::NUM_BANDS))
                       ? rbe_pkg::CNT_W'(rbe_pkg::NUM_BANDS) : r_active;
    assign last_band = (({1'b0, r_addr} + 8'd1) == n_bands);
    assign out_free  = !r_out_valid || !i_out_stall;

    // sample pick, floor of the average in stereo
    assign smp_in = r_stereo ? ((17'(i_in_data.left) + 17'(i_in_data.right)) >>> 1)
                             : 17'(i_in_data.left);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 8'd94;
            r_stereo <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbe_pkg::CFG_ACTIVE_BANDS: r_active <= i_cfg_data;
                rbe_pkg::CFG_STEREO:       r_stereo <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority case (i_in_data.req_type)
                        rbe_pkg::REQ_LOAD, rbe_pkg::REQ_READ: n_state = S_RD;
                        rbe_pkg::REQ_SAMPLE: n_state = (n_bands == '0) ? S_IDLE : S_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: n_state = S_LAT;
            S_LAT: begin
                priority case (r_req)
                    rbe_pkg::REQ_SAMPLE: n_state = S_MUL;
                    rbe_pkg::REQ_READ:   n_state = out_free ? S_IDLE : S_LAT;
                    default:             n_state = S_IDLE;
                endcase
            end
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = (r_op == rbe_pkg::OP_LAST) ? S_WB : S_MUL;
            S_WB:  n_state = last_band ? S_IDLE : S_RD;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_op        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LAT && r_req == rbe_pkg::REQ_READ && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_LAT) begin
                r_op <= '0;
            end else if (r_state == S_ACC && r_op != rbe_pkg::OP_LAST) begin
                r_op <= r_op + 5'd1;
            end
        end
    end

    // request capture, band walk and output beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_req  <= i_in_data.req_type;
            r_smp  <= smp_in;
            r_addr <= (i_in_data.req_type == rbe_pkg::REQ_SAMPLE) ? '0 : i_in_data.band;
        end else if (r_state == S_WB && !last_band) begin
            r_addr <= r_addr + 7'd1;
        end
        if (r_state == S_LAT && r_req == rbe_pkg::REQ_READ && out_free) begin
            r_out.out_band  <= r_addr;
            r_out.energy    <= st_rdata.energy;
            r_out.saturated <= st_rdata.sat;
        end
    end

    // memory port control
    always_comb begin
        coef_we          = r_state == S_IDLE && in_acc && i_in_data.req_type == rbe_pkg::REQ_LOAD;
        coef_wdata.cos   = i_in_data.coef_cos;
        coef_wdata.sin   = i_in_data.coef_sin;
        coef_wdata.decay = i_in_data.coef_decay;
        coef_wdata.scale = i_in_data.coef_scale;
        st_re            = r_state == S_RD;
        st_we            = 1'b0;
        st_wdata         = dp_state;
        if (r_state == S_LAT && r_req == rbe_pkg::REQ_LOAD) begin
            st_we       = 1'b1;
            st_wdata    = st_rdata;
            st_wdata.re = '0;
            st_wdata.im = '0;
        end else if (r_state == S_LAT && r_req == rbe_pkg::REQ_READ && out_free) begin
            st_we           = 1'b1;
            st_wdata        = st_rdata;
            st_wdata.energy = '0;
            st_wdata.sat    = 1'b0;
        end else if (r_state == S_WB) begin
            st_we = 1'b1;
        end
        dp_ctrl.latch = r_state == S_LAT && r_req == rbe_pkg::REQ_SAMPLE;
        dp_ctrl.mul   = r_state == S_MUL;
        dp_ctrl.acc   = r_state == S_ACC;
        dp_ctrl.op    = r_op;
    end

    rbe_coef_mem u_coef (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (i_in_data.band),
        .i_wdata (coef_wdata),
        .i_re    (st_re),
        .i_raddr (r_addr),
        .o_rdata (coef_rdata)
    );

    rbe_state_mem u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (r_addr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (r_addr),
        .o_rdata (st_rdata)
    );

    rbe_datapath u_dp (
        .i_clk   (i_clk),
        .i_ctrl  (dp_ctrl),
        .i_coef  (coef_rdata),
        .i_state (st_rdata),
        .i_smp   (r_smp),
        .o_state (dp_state)
    );

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an output beat only starts from a read request
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_LAT && r_req == rbe_pkg::REQ_READ))
        else $error("output beat without read request");

    // micro-step counter stays in range
    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op <= rbe_pkg::OP_LAST)
        else $error("micro-step out of range");

    // write-back goes to the next band or ends the sample
    a_wb_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB |=> (r_state == S_RD || r_state == S_IDLE))
        else $error("bad state after write-back");

endmodule
